### design/ttrc_pkg.sv
// Shared types and constants for the tree threshold reach counter.
`default_nettype none
package ttrc_pkg;
	localparam int NODE_W  = 10;
	localparam int WT_W    = 31;
	localparam int COUNT_W = 10;
	localparam logic [WT_W-1:0]    WEIGHT_CAP = 31'd1000000000;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_WRA,
		ST_ADD_RDB,
		ST_ADD_WRB,
		ST_Q_HEAD,
		ST_Q_STEP,
		ST_Q_EDGE,
		ST_Q_POP,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

### design/ttrc_in_if.sv
// Input channel: one command item per transfer.
`default_nettype none
interface ttrc_in_if;
	import ttrc_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [WT_W-1:0]     edge_weight;
	logic [WT_W-1:0]     threshold;
	modport source (output valid, op, node_a, node_b, edge_weight, threshold, input ready);
	modport sink   (input valid, op, node_a, node_b, edge_weight, threshold, output ready);
endinterface
`default_nettype wire

### design/ttrc_out_if.sv
// Result channel: one reach count per transfer.
`default_nettype none
interface ttrc_out_if;
	import ttrc_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] reach_count;
	modport source (output valid, reach_count, input ready);
	modport sink   (input valid, reach_count, output ready);
endinterface
`default_nettype wire

### design/ttrc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none
module ttrc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### design/tree_threshold_reach_count_top.sv
// Tree reach counter: adjacency lists in RAM, depth-first walk over a RAM stack.
// Steps: an add edge writes entry A, reads head B and writes entry B; a clear sweeps all
//   heads; a query looks at each edge entry, enters each node taken and pops each finished frame.
// Throughput: one item at a time; the next input transfer is taken once the current
//   item is done and, for a query, its result has entered the output register.
// Reset: a sweep writes the empty mark into every head; no input meanwhile.
`default_nettype none
module tree_threshold_reach_count_top #(
	parameter int MAX_NODES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	ttrc_in_if.sink   in_ch,
	ttrc_out_if.source out_ch
);
	import ttrc_pkg::*;

	// Edge table holds two entries per tree edge; its size is also the empty mark.
	localparam int EDGE_CAP = 2 * (MAX_NODES - 1);
	localparam int EW  = $clog2(EDGE_CAP + 1);  // head / cursor values incl. empty mark
	localparam int EAW = $clog2(EDGE_CAP);      // edge RAM address
	localparam int NW  = $clog2(MAX_NODES);     // head RAM / stack address
	localparam int SPW = $clog2(MAX_NODES + 1); // stack depth counter
	localparam logic [EW-1:0] EMPTY_MARK = EW'(EDGE_CAP);
	localparam int EDW = EW + NODE_W + WT_W;    // {next, dest, weight}
	localparam int FRW = NODE_W + NODE_W + EW;  // {node, parent, cursor}

	function automatic logic [NW-1:0] nidx(input logic [NODE_W-1:0] n);
		logic [31:0] t;
		t = 32'(n);
		return t[NW-1:0];
	endfunction

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		return 32'(n) < MAX_NODES;
	endfunction

	state_t state_q, state_d;

	// captured command
	logic [1:0]        op_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic [WT_W-1:0]   w_q, thr_q;

	logic [EW-1:0]      used_q;
	logic [NW-1:0]      sweep_q;
	logic [SPW-1:0]     sp_q;
	logic [COUNT_W-1:0] count_q;
	// top frame of the walk lives in registers; the rest sit in the stack RAM
	logic [NODE_W-1:0]  top_node_q, top_par_q;
	logic [EW-1:0]      top_cur_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_data_q;

	// RAM ports
	logic          h_we, h_re;
	logic [NW-1:0] h_waddr, h_raddr;
	logic [EW-1:0] h_wdata, h_rdata;
	logic           e_we, e_re;
	logic [EAW-1:0] e_waddr, e_raddr;
	logic [EDW-1:0] e_wdata, e_rdata;
	logic          s_we, s_re;
	logic [NW-1:0] s_waddr, s_raddr;
	logic [FRW-1:0] s_wdata, s_rdata;

	ttrc_ram #(.DEPTH(MAX_NODES), .WIDTH(EW)) u_head (
		.clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);
	ttrc_ram #(.DEPTH(EDGE_CAP), .WIDTH(EDW)) u_edge (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(e_re), .raddr(e_raddr), .rdata(e_rdata)
	);
	ttrc_ram #(.DEPTH(MAX_NODES), .WIDTH(FRW)) u_stack (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	// fields of the edge entry just read
	logic [EW-1:0]     ed_next;
	logic [NODE_W-1:0] ed_dest;
	logic [WT_W-1:0]   ed_wt, ed_wt_cap;
	assign {ed_next, ed_dest, ed_wt} = e_rdata;
	assign ed_wt_cap = (ed_wt > WEIGHT_CAP) ? WEIGHT_CAP : ed_wt;

	logic edge_take, can_push, add_ok, out_free;
	logic [SPW-1:0] sp_m1, sp_m2;
	assign edge_take = (ed_dest != top_par_q) && !(ed_wt_cap < thr_q);
	assign can_push  = (32'(sp_q) < MAX_NODES) && node_ok(ed_dest);
	assign add_ok    = node_ok(a_q) && node_ok(b_q) && (32'(used_q) + 2 <= EDGE_CAP);
	assign sp_m1     = sp_q - SPW'(1);
	assign sp_m2     = sp_q - SPW'(2);
	assign out_free  = !out_valid_q || out_ch.ready;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.reach_count = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM controls
	always_comb begin
		state_d = state_q;
		h_we = 1'b0; h_waddr = sweep_q; h_wdata = EMPTY_MARK;
		h_re = 1'b0; h_raddr = nidx(a_q);
		e_we = 1'b0; e_waddr = used_q[EAW-1:0]; e_wdata = {h_rdata, b_q, w_q};
		e_re = 1'b0; e_raddr = top_cur_q[EAW-1:0];
		s_we = 1'b0; s_waddr = sp_m1[NW-1:0]; s_wdata = {top_node_q, top_par_q, ed_next};
		s_re = 1'b0; s_raddr = sp_m2[NW-1:0];
		unique case (state_q)
			ST_SWEEP: begin
				h_we = 1'b1;
				if (32'(sweep_q) == MAX_NODES - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_ch.valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (op_q)
					OP_ADD: begin
						if (add_ok) begin
							h_re = 1'b1;
							state_d = ST_ADD_WRA;
						end else begin
							state_d = ST_IDLE;
						end
					end
					OP_QUERY: begin
						if (node_ok(a_q)) begin
							h_re = 1'b1;
							state_d = ST_Q_HEAD;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_CLEAR: state_d = ST_SWEEP;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_ADD_WRA: begin
				e_we = 1'b1;
				h_we = 1'b1; h_waddr = nidx(a_q); h_wdata = used_q;
				state_d = ST_ADD_RDB;
			end
			ST_ADD_RDB: begin
				h_re = 1'b1; h_raddr = nidx(b_q);
				state_d = ST_ADD_WRB;
			end
			ST_ADD_WRB: begin
				e_we = 1'b1; e_wdata = {h_rdata, a_q, w_q};
				h_we = 1'b1; h_waddr = nidx(b_q); h_wdata = used_q;
				state_d = ST_IDLE;
			end
			ST_Q_HEAD: state_d = ST_Q_STEP;
			ST_Q_STEP: begin
				if (sp_q == '0 || count_q == COUNT_MAX) begin
					state_d = ST_DONE;
				end else if (32'(top_cur_q) >= EDGE_CAP) begin
					// list done: pop, reload the frame below if any
					if (sp_q == SPW'(1)) begin
						state_d = ST_DONE;
					end else begin
						s_re = 1'b1;
						state_d = ST_Q_POP;
					end
				end else begin
					e_re = 1'b1;
					state_d = ST_Q_EDGE;
				end
			end
			ST_Q_EDGE: begin
				if (edge_take && can_push) begin
					s_we = 1'b1;
					h_re = 1'b1; h_raddr = nidx(ed_dest);
					state_d = ST_Q_HEAD;
				end else begin
					state_d = ST_Q_STEP;
				end
			end
			ST_Q_POP: state_d = ST_Q_STEP;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SWEEP) begin
				sweep_q <= (32'(sweep_q) == MAX_NODES - 1) ? '0 : sweep_q + NW'(1);
				used_q  <= '0;
			end
			if (state_q == ST_ADD_WRA || state_q == ST_ADD_WRB) begin
				used_q <= used_q + EW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			op_q  <= in_ch.op;
			a_q   <= in_ch.node_a;
			b_q   <= in_ch.node_b;
			w_q   <= in_ch.edge_weight;
			thr_q <= in_ch.threshold;
		end
		unique case (state_q)
			ST_DISPATCH: begin
				count_q    <= '0;
				sp_q       <= SPW'(1);
				top_node_q <= a_q;
				top_par_q  <= a_q;
			end
			ST_Q_HEAD: top_cur_q <= h_rdata;
			ST_Q_STEP: begin
				if (sp_q != '0 && count_q != COUNT_MAX && 32'(top_cur_q) >= EDGE_CAP) begin
					sp_q <= sp_m1;
				end
			end
			ST_Q_EDGE: begin
				top_cur_q <= ed_next;
				if (edge_take) begin
					count_q <= count_q + COUNT_W'(1);
					if (can_push) begin
						top_node_q <= ed_dest;
						top_par_q  <= top_node_q;
						sp_q       <= sp_q + SPW'(1);
					end
				end
			end
			ST_Q_POP: {top_node_q, top_par_q, top_cur_q} <= s_rdata;
			ST_DONE: begin
				if (out_free) out_data_q <= node_ok(a_q) ? count_q : '0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### dv/tb_tree_threshold_reach_count_top.sv
// Testbench for the tree threshold reach counter: directed and random items checked by a predictor.
`default_nettype none
module tb_tree_threshold_reach_count_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ttrc_pkg::*;

	localparam int NODES    = 1024;
	localparam int ENTRIES  = 2 * (NODES - 1);
	localparam int HUSH     = ENTRIES;          // empty head mark
	localparam int CAP      = 1000000000;
	localparam int STALL_LIMIT = 60000;         // idle cycles before giving up
	localparam int TAIL     = 1200;             // covers a clear after the last result

	logic clk;
	logic arst_n;

	ttrc_in_if  in_ch();
	ttrc_out_if out_ch();

	tree_threshold_reach_count_top #(.MAX_NODES(NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Clock: 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor state: own copy of the adjacency lists.
	// ---------------------------------------------------------------
	int unsigned head_tab[NODES];
	int unsigned next_tab[ENTRIES];
	int unsigned dest_tab[ENTRIES];
	int unsigned wt_tab[ENTRIES];
	int unsigned used_cnt;

	logic [COUNT_W-1:0] count_q[$];   // reach counts still owed by the block

	int  mismatches;
	bit  quiet_mode;    // no random gaps on either side
	bit  hold_rx;       // receiver stalls for a long stretch once
	int  idle_cycles = 0;

	function automatic void forest_clear();
		for (int i = 0; i < NODES; i++)
			head_tab[i] = HUSH;
		used_cnt = 0;
	endfunction

	function automatic void link_one(int unsigned from, int unsigned to, int unsigned w);
		dest_tab[used_cnt] = to;
		wt_tab[used_cnt]   = w;
		next_tab[used_cnt] = head_tab[from];
		head_tab[from]     = used_cnt;
		used_cnt++;
	endfunction

	// Depth-first walk over edges whose capped weight meets the threshold.
	function automatic int unsigned reach_from(int unsigned start, int unsigned thr);
		int unsigned fr_node[NODES];
		int unsigned fr_par[NODES];
		int unsigned fr_cur[NODES];
		int unsigned sp;
		int unsigned cnt;
		int unsigned e;
		int unsigned d;
		int unsigned w;
		cnt = 0;
		if (start >= NODES)
			return 0;
		fr_node[0] = start;
		fr_par[0]  = start;
		fr_cur[0]  = head_tab[start];
		sp = 1;
		while (sp > 0 && cnt < COUNT_MAX) begin
			e = fr_cur[sp-1];
			if (e >= ENTRIES) begin
				sp--;
				continue;
			end
			fr_cur[sp-1] = next_tab[e];
			d = dest_tab[e];
			if (d == fr_par[sp-1])
				continue;
			w = wt_tab[e];
			if (w > CAP)
				w = CAP;
			if (w < thr)
				continue;
			cnt++;
			if (sp < NODES && d < NODES) begin
				fr_node[sp] = d;
				fr_par[sp]  = fr_node[sp-1];
				fr_cur[sp]  = head_tab[d];
				sp++;
			end
		end
		return cnt;
	endfunction

	// Apply one accepted item to the predictor.
	function automatic void apply_item(op_t op, logic [9:0] a, logic [9:0] b,
			logic [30:0] w, logic [30:0] thr);
		case (op)
		OP_ADD: begin
			if (used_cnt + 2 <= ENTRIES) begin
				link_one(a, b, w);
				link_one(b, a, w);
			end
		end
		OP_QUERY: count_q = {count_q, COUNT_W'(reach_from(a, thr))};
		OP_CLEAR: forest_clear();
		default: ;
		endcase
	endfunction

	function automatic int draw_gap();
		if (quiet_mode)
			return 0;
		return $urandom_range(13, 0);
	endfunction

	// ---------------------------------------------------------------
	// Sender: called at a falling edge, returns at a falling edge with
	// valid still high so the next item can follow without a bubble.
	// ---------------------------------------------------------------
	task automatic send_item(op_t op, logic [9:0] a, logic [9:0] b,
			logic [30:0] w, logic [30:0] thr);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.op          <= op;
		in_ch.node_a      <= a;
		in_ch.node_b      <= b;
		in_ch.edge_weight <= w;
		in_ch.threshold   <= thr;
		// ready only moves at rising edges, so it is stable here
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		apply_item(op, a, b, w, thr);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed count has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		wait (count_q.size() == 0);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Receiver and checker.
	// ---------------------------------------------------------------
	initial begin
		int gap;
		logic [COUNT_W-1:0] got;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (hold_rx) begin
				hold_rx = 1'b0;
				gap += 400;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			while (!out_ch.valid) @(negedge clk);
			got = out_ch.reach_count;
			@(posedge clk);
			if (count_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reach count %0d with nothing owed", got);
			end else if (got !== count_q[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reach_count mismatch: expected %0d got %0d",
						count_q[0], got);
				void'(count_q.pop_front());
			end else begin
				void'(count_q.pop_front());
			end
			@(negedge clk);
		end
	end

	// Watchdog: cycles without any transfer on either channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Small path with a self loop; thresholds at the edges of the cap.
	task automatic test_directed();
		send_item(OP_ADD, 10'd5, 10'd6, 31'd100, 31'd0);
		send_item(OP_ADD, 10'd6, 10'd7, 31'h7FFF_FFFF, 31'd0);
		send_item(OP_ADD, 10'd5, 10'd5, 31'd500, 31'd0);       // self loop
		send_item(OP_ADD, 10'd1023, 10'd0, 31'd0, 31'h7FFF_FFFF);
		send_item(OP_ADD, 10'd7, 10'd1023, 31'd1000000001, 31'd0);
		send_item(OP_QUERY, 10'd5, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd5, 10'h3FF, 31'h7FFF_FFFF, 31'd100);
		send_item(OP_QUERY, 10'd5, 10'd0, 31'd0, 31'd101);
		send_item(OP_QUERY, 10'd7, 10'd0, 31'd0, 31'd1000000000); // capped weights pass
		send_item(OP_QUERY, 10'd7, 10'd0, 31'd0, 31'd1000000001); // capped weights fail
		send_item(OP_QUERY, 10'd6, 10'd0, 31'd0, 31'h7FFF_FFFF);
		send_item(OP_QUERY, 10'd1023, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd0, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd300, 10'd0, 31'd0, 31'd0);      // isolated node
		send_item(OP_NONE, 10'd5, 10'd6, 31'd7, 31'd0);         // unused op
		send_item(OP_QUERY, 10'd5, 10'd0, 31'd0, 31'd0);
		send_item(OP_CLEAR, 10'd0, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd5, 10'd0, 31'd0, 31'd0);
		drain_results();
	endtask

	// A triangle is not a tree: the count saturates when its edges pass the threshold.
	task automatic test_cycle();
		send_item(OP_ADD, 10'd1, 10'd2, 31'd9, 31'd0);
		send_item(OP_ADD, 10'd2, 10'd3, 31'd9, 31'd0);
		send_item(OP_ADD, 10'd3, 10'd1, 31'd9, 31'd0);
		send_item(OP_QUERY, 10'd1, 10'd0, 31'd0, 31'd5);
		send_item(OP_QUERY, 10'd1, 10'd0, 31'd0, 31'd10);
		send_item(OP_CLEAR, 10'd0, 10'd0, 31'd0, 31'd0);
		drain_results();
	endtask

	// Long path: deep stack, walked from both ends and the middle.
	task automatic test_long_path();
		quiet_mode = 1'b1;
		for (int i = 0; i < 60; i++)
			send_item(OP_ADD, 10'(i), 10'(i + 1), 31'($urandom_range(50, 20)), 31'd0);
		quiet_mode = 1'b0;
		send_item(OP_QUERY, 10'd0, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd60, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd30, 10'd0, 31'd0, 31'd35);
		send_item(OP_CLEAR, 10'd0, 10'd0, 31'd0, 31'd0);
		send_item(OP_QUERY, 10'd0, 10'd0, 31'd0, 31'd0);
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering queries.
	task automatic test_backpressure();
		send_item(OP_ADD, 10'd40, 10'd41, 31'd3, 31'd0);
		hold_rx = 1'b1;
		quiet_mode = 1'b1;
		for (int i = 0; i < 6; i++)
			send_item(OP_QUERY, 10'(40 + (i & 1)), 10'd0, 31'd0, 31'(i & 3));
		quiet_mode = 1'b0;
		send_item(OP_CLEAR, 10'd0, 10'd0, 31'd0, 31'd0);
		drain_results();
	endtask

	function automatic logic [30:0] rand_weight();
		case ($urandom_range(4, 0))
		0: return 31'($urandom);
		1: return 31'($urandom_range(1000000002, 999999998));
		default: return 31'($urandom_range(60, 0));
		endcase
	endfunction

	// Random segments: each clears, then mixes adds, queries and unused ops in a small or full node window.
	task automatic test_random();
		int span;
		int base;
		int pick;
		logic [9:0] a;
		logic [9:0] b;
		for (int seg = 0; seg < 8; seg++) begin
			quiet_mode = (seg % 4 == 3);
			span = (seg % 3 == 0) ? 1024 : $urandom_range(24, 4);
			base = (span == 1024) ? 0 : $urandom_range(1023 - span, 0);
			send_item(OP_CLEAR, 10'($urandom), 10'($urandom), 31'($urandom), 31'($urandom));
			for (int k = 0; k < 23; k++) begin
				pick = $urandom_range(9, 0);
				a = 10'(base + $urandom_range(span - 1, 0));
				b = 10'(base + $urandom_range(span - 1, 0));
				if (pick < 5)
					send_item(OP_ADD, a, b, rand_weight(), 31'($urandom));
				else if (pick < 9)
					send_item(OP_QUERY, a, 10'($urandom), 31'($urandom), rand_weight());
				else
					send_item(OP_NONE, a, b, 31'($urandom), 31'($urandom));
			end
		end
		quiet_mode = 1'b0;
		drain_results();
	endtask

	initial begin
		mismatches  = 0;
		quiet_mode  = 1'b0;
		hold_rx     = 1'b0;
		forest_clear();
		arst_n = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.op          = OP_NONE;
		in_ch.node_a      = '0;
		in_ch.node_b      = '0;
		in_ch.edge_weight = '0;
		in_ch.threshold   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_cycle();
		test_backpressure();
		test_long_path();
		test_random();

		// Let a trailing clear finish before the verdict.
		repeat (TAIL) @(negedge clk);
		if (mismatches == 0 && count_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
